// File: src/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
package bba_pkg;

  localparam int unsigned GRAN_W     = 15;  // granule index bits (1 MiB / 32 B)
  localparam int unsigned LVL_W      = 5;
  localparam int unsigned NUM_LEVELS = 26;
  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned BYTES_W    = 21;

  localparam logic [LVL_W-1:0] TOP_LOG2   = 5'd30;
  localparam logic [LVL_W-1:0] HEAP_LOG2  = 5'd20;
  localparam logic [LVL_W-1:0] CHUNK_LOG2 = 5'd18;
  localparam logic [LVL_W-1:0] MIN_LOG2   = 5'd5;
  localparam logic [LVL_W-1:0] START_LVL  = 5'd12;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FIND    = 8'b0000_0010,
    S_POP     = 8'b0000_0100,
    S_SPLIT_A = 8'b0000_1000,
    S_SPLIT_B = 8'b0001_0000,
    S_FREE_RD = 8'b0010_0000,
    S_FREE_WR = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  typedef logic [GRAN_W-1:0] gran_t;

endpackage

// File: src/buddy_block_allocator_core.sv
// Buddy block allocator core: sequencer, free lists and link memories.
// One word in, one word out. A free reads the link and level memories, then
// pushes the block onto the head list of its level. An allocate searches, then
// pops a block or splits one level per pass, and grows the heap at most once. A
// rejected word goes straight to the done state. The block returns to idle before
// the next word is taken. The link and level memories have registered reads. The
// result sits in an output register, so the next word may enter while it waits.
module buddy_block_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bba_pkg::BYTES_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [bba_pkg::BYTES_W-1:0]  req_bytes_i,
  input  logic [bba_pkg::ADDR_W-1:0]   payload_addr_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [bba_pkg::ADDR_W-1:0]   block_addr_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  logic [BYTES_W-1:0] limit_q;
  logic [BYTES_W-1:0] hb_q, hb_d;
  gran_t              head_q [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] hv_q;

  logic [LVL_W-1:0] lvl_q, lvl_d, p_q, p_d, idx_q, idx_d;
  gran_t            g_q, g_d, u_q, u_d;
  logic             grown_q, grown_d;
  logic             pend_ok_q, pend_ok_d;
  logic             out_valid_q;
  logic             ok_q;
  logic [ADDR_W-1:0] addr_q;
  logic             kind_alloc_q;

  // link and level memories
  logic [GRAN_W:0]  nl_mem [2**GRAN_W];
  logic [LVL_W-1:0] bl_mem [2**GRAN_W];
  logic             nl_we, bl_we;
  gran_t            nl_waddr, bl_waddr, nl_raddr, bl_raddr;
  logic [GRAN_W:0]  nl_wdata, nl_rdata_q, nl_rd;
  logic [LVL_W-1:0] bl_wdata, bl_rdata_q;
  logic             nl0_fresh_q, nl_rz_q;
  logic             bl0_fresh_q;
  logic [LVL_W-1:0] fr_lvl;

  // head register file write
  logic             head_we;
  logic [LVL_W-1:0] head_widx, head_ridx;
  gran_t            head_wdata, head_rd;
  logic             head_wv;

  // combinational helpers
  logic [BYTES_W:0] t_req;
  logic [LVL_W-1:0] p_raw, p_cl;
  logic             find_hit;
  logic [LVL_W-1:0] find_idx, tl;
  logic [BYTES_W:0] csz, lim, hb_sum;
  logic             grow_ok;
  logic [ADDR_W-1:0] off;
  logic [LVL_W-1:0] shamt;

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      nl_mem[nl_waddr] <= nl_wdata;
    end
    nl_rdata_q <= nl_mem[nl_raddr];
    if (bl_we) begin
      bl_mem[bl_waddr] <= bl_wdata;
    end
    bl_rdata_q <= bl_mem[bl_raddr];
  end

  // link of the reset block reads as empty until written
  assign nl_rd = nl_rz_q ? '0 : nl_rdata_q;
  assign head_rd = head_q[head_ridx];

  always_comb begin
    t_req = {1'b0, req_bytes_i} + (BYTES_W+1)'(15);
    p_raw = '0;
    for (int i = 0; i <= BYTES_W; i++) begin
      if (t_req[i]) p_raw = LVL_W'(i + 1);
    end
    p_cl = (p_raw < MIN_LOG2) ? MIN_LOG2 : p_raw;
    off = payload_addr_i - ADDR_W'(16);
    // level of the reset block reads as its start level until written
    fr_lvl = (bl0_fresh_q && g_q == '0) ? START_LVL : bl_rdata_q;

    find_hit = 1'b0;
    find_idx = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (hv_q[i] && (LVL_W'(i) <= lvl_q)) begin
        find_hit = 1'b1;
        find_idx = LVL_W'(i);
      end
    end

    if (p_q > CHUNK_LOG2) begin
      csz = (BYTES_W+1)'(1) << p_q;
      tl  = lvl_q;
    end else begin
      csz = (BYTES_W+1)'(1) << CHUNK_LOG2;
      tl  = START_LVL;
    end
    lim = (limit_q > BYTES_W'(1 << 20)) ? (BYTES_W+1)'(1 << 20)
                                        : {1'b0, limit_q};
    hb_sum  = {1'b0, hb_q} + csz;
    grow_ok = !grown_q && (hb_sum <= lim);
    shamt   = LVL_W'(24) - idx_q;
  end

  always_comb begin
    state_d   = state_q;
    hb_d      = hb_q;
    lvl_d     = lvl_q;
    p_d       = p_q;
    idx_d     = idx_q;
    g_d       = g_q;
    u_d       = u_q;
    grown_d   = grown_q;
    pend_ok_d = pend_ok_q;
    nl_we = 1'b0; nl_waddr = g_q; nl_wdata = '0; nl_raddr = g_q;
    bl_we = 1'b0; bl_waddr = g_q; bl_wdata = '0;
    bl_raddr = g_q;
    head_we = 1'b0; head_widx = idx_q; head_wdata = '0; head_wv = 1'b0;
    head_ridx = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pend_ok_d = 1'b0;
          g_d       = off[ADDR_W-1:5];
          grown_d   = 1'b0;
          p_d       = p_cl;
          lvl_d     = TOP_LOG2 - p_cl;
          if (kind_i == KIND_FREE) begin
            if (payload_addr_i < ADDR_W'(16) || off[4:0] != '0 ||
                {1'b0, off} >= hb_q) begin
              state_d = S_DONE;
            end else begin
              state_d = S_FREE_RD;
            end
          end else if (req_bytes_i == '0 || p_cl > HEAP_LOG2) begin
            state_d = S_DONE;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        head_ridx = find_hit ? find_idx : tl;
        if (find_hit) begin
          g_d      = head_rd;
          idx_d    = find_idx;
          nl_raddr = head_rd;
          state_d  = (find_idx == lvl_q) ? S_POP : S_SPLIT_A;
        end else if (grow_ok) begin
          // push the new chunk at the old break
          nl_we      = 1'b1;
          nl_waddr   = hb_q[ADDR_W-1:5];
          nl_wdata   = {hv_q[tl], head_rd};
          bl_we      = 1'b1;
          bl_waddr   = hb_q[ADDR_W-1:5];
          bl_wdata   = tl;
          head_we    = 1'b1;
          head_widx  = tl;
          head_wdata = hb_q[ADDR_W-1:5];
          head_wv    = 1'b1;
          hb_d       = hb_sum[BYTES_W-1:0];
          grown_d    = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        head_we    = 1'b1;
        head_widx  = lvl_q;
        head_wdata = nl_rd[GRAN_W-1:0];
        head_wv    = nl_rd[GRAN_W];
        bl_we      = 1'b1;
        bl_wdata   = lvl_q;
        pend_ok_d  = 1'b1;
        state_d    = S_DONE;
      end
      S_SPLIT_A: begin
        u_d        = g_q + (gran_t'(1) << shamt);
        head_we    = 1'b1;
        head_wdata = nl_rd[GRAN_W-1:0];
        head_wv    = nl_rd[GRAN_W];
        nl_we      = 1'b1;
        nl_waddr   = u_d;
        bl_we      = 1'b1;
        bl_waddr   = u_d;
        bl_wdata   = idx_q + LVL_W'(1);
        state_d    = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        nl_we      = 1'b1;
        nl_wdata   = {1'b1, u_q};
        bl_we      = 1'b1;
        bl_wdata   = idx_q + LVL_W'(1);
        head_we    = 1'b1;
        head_widx  = idx_q + LVL_W'(1);
        head_wdata = g_q;
        head_wv    = 1'b1;
        state_d    = S_FIND;
      end
      S_FREE_RD: begin
        state_d = S_FREE_WR;
      end
      S_FREE_WR: begin
        head_ridx = fr_lvl;
        if (fr_lvl < LVL_W'(NUM_LEVELS)) begin
          nl_we      = 1'b1;
          nl_wdata   = {hv_q[fr_lvl], head_rd};
          head_we    = 1'b1;
          head_widx  = fr_lvl;
          head_wdata = g_q;
          head_wv    = 1'b1;
          pend_ok_d  = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= BYTES_W'(1 << 20);
      hb_q        <= BYTES_W'(1 << 18);
      hv_q        <= NUM_LEVELS'(1) << START_LVL;
      for (int i = 0; i < NUM_LEVELS; i++) head_q[i] <= '0;
      nl0_fresh_q <= 1'b1;
      bl0_fresh_q <= 1'b1;
      nl_rz_q     <= 1'b0;
      out_valid_q <= 1'b0;
      grown_q     <= 1'b0;
      pend_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      hb_q      <= hb_d;
      grown_q   <= grown_d;
      pend_ok_q <= pend_ok_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (head_we) begin
        head_q[head_widx] <= head_wdata;
        hv_q[head_widx]   <= head_wv;
      end
      if (nl_we && nl_waddr == '0) nl0_fresh_q <= 1'b0;
      if (bl_we && bl_waddr == '0) bl0_fresh_q <= 1'b0;
      nl_rz_q <= nl0_fresh_q && (nl_raddr == '0);
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    p_q   <= p_d;
    idx_q <= idx_d;
    g_q   <= g_d;
    u_q   <= u_d;
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      ok_q   <= pend_ok_q;
      // free words and failures carry a zero address
      addr_q <= (pend_ok_q && lvl_q != '0 && kind_alloc_q) ? {g_q, 5'b10000} : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) kind_alloc_q <= (kind_i == KIND_ALLOC);
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign block_addr_o = addr_q;

endmodule

// File: src/bba_checker.sv
// Port checker for the buddy block allocator core and its bind.
module bba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        ok_o,
  input logic [bba_pkg::ADDR_W-1:0]  block_addr_o
);
  import bba_pkg::*;

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) && $stable(block_addr_o))
    else $error("result word changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> block_addr_o == '0)
    else $error("failed word carries an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_addr_o != '0 |-> block_addr_o[4:0] == 5'b10000)
    else $error("granted address off the granule grid");

  // one word at a time: stall right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ok_o         (ok_o),
  .block_addr_o (block_addr_o)
);

// File: test/tb.sv
// Self-checking testbench of the buddy block allocator core.
module tb;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [15:0] LINK_VLD = 16'h8000;

  typedef struct packed {
    logic                kind;
    logic [BYTES_W-1:0]  req_bytes;
    logic [ADDR_W-1:0]   payload_addr;
  } alloc_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] block_addr;
  } alloc_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [BYTES_W-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                kind_i = KIND_ALLOC;
  logic [BYTES_W-1:0]  req_bytes_i = '0;
  logic [ADDR_W-1:0]   payload_addr_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                ok_o;
  logic [ADDR_W-1:0]   block_addr_o;

  buddy_block_allocator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .req_bytes_i   (req_bytes_i),
    .payload_addr_i(payload_addr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .block_addr_o  (block_addr_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow allocator state.
  logic [15:0]         head_q[NUM_LEVELS];
  logic [15:0]         link_mem[1 << GRAN_W];
  logic [LVL_W-1:0]    lvl_mem[1 << GRAN_W];
  logic [BYTES_W-1:0]  brk_q;
  logic [BYTES_W-1:0]  limit_q;

  alloc_req_t          pending_q[$];
  alloc_rsp_t          expected_q[$];
  logic [ADDR_W-1:0]   granted_q[$];
  int unsigned         errors = 0;
  int unsigned         cycles = 0;
  bit                  calm = 1'b0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (calm || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_free(int lv, gran_t g);
    link_mem[g] = head_q[lv];
    head_q[lv]  = LINK_VLD | 16'(g);
    lvl_mem[g]  = LVL_W'(lv);
  endfunction

  function automatic gran_t pop_free(int lv);
    gran_t g;
    g = gran_t'(head_q[lv]);
    head_q[lv] = link_mem[g];
    return g;
  endfunction

  // Search for a block at level lv, splitting larger ones down; -1 if none.
  function automatic int take_block(int lv);
    int    idx;
    gran_t g, u;
    idx = lv;
    while (idx >= 0 && !head_q[idx][15]) idx--;
    if (idx < 0) return -1;
    while (idx < lv) begin
      g = pop_free(idx);
      u = g + gran_t'(1 << (TOP_LOG2 - idx - 1 - MIN_LOG2));
      lvl_mem[g] = LVL_W'(idx + 1);
      lvl_mem[u] = LVL_W'(idx + 1);
      link_mem[u] = '0;
      link_mem[g] = LINK_VLD | 16'(u);
      head_q[idx + 1] = LINK_VLD | 16'(g);
      idx++;
    end
    g = pop_free(lv);
    lvl_mem[g] = LVL_W'(lv);
    return int'(g);
  endfunction

  function automatic void grow_heap(int lv, int unsigned p);
    longint unsigned csz, lim;
    int tl;
    csz = 64'd1 << CHUNK_LOG2;
    tl  = TOP_LOG2 - CHUNK_LOG2;
    lim = limit_q;
    if ((64'd1 << p) > csz) begin
      csz = 64'd1 << p;
      tl  = lv;
    end
    if (lim > (64'd1 << HEAP_LOG2)) lim = 64'd1 << HEAP_LOG2;
    if (tl < 0 || tl >= NUM_LEVELS) return;
    if (brk_q + csz > lim) return;
    push_free(tl, gran_t'(brk_q >> MIN_LOG2));
    brk_q = BYTES_W'(brk_q + csz);
  endfunction

  function automatic alloc_rsp_t predict_alloc(alloc_req_t it);
    alloc_rsp_t r;
    longint unsigned adj;
    int unsigned p;
    int lv, g;
    r = '0;
    if (it.kind == KIND_ALLOC) begin
      if (it.req_bytes == 0) return r;
      adj = it.req_bytes + 16;
      p = 0;
      while ((64'd1 << p) < adj) p++;
      if (p < MIN_LOG2) p = MIN_LOG2;
      if (p > HEAP_LOG2) return r;
      lv = TOP_LOG2 - p;
      g = take_block(lv);
      if (g < 0) begin
        grow_heap(lv, p);
        g = take_block(lv);
      end
      if (g >= 0) begin
        r.ok = 1'b1;
        r.block_addr = ADDR_W'((g << MIN_LOG2) + 16);
        granted_q.push_back(r.block_addr);
      end
    end else begin
      if (it.payload_addr < 16) return r;
      if ((it.payload_addr - 16) % 32 != 0) return r;
      if (BYTES_W'(it.payload_addr - 16) >= brk_q) return r;
      g = int'((it.payload_addr - 16) >> MIN_LOG2);
      if (lvl_mem[g] >= NUM_LEVELS) return r;
      push_free(int'(lvl_mem[g]), gran_t'(g));
      r.ok = 1'b1;
    end
    return r;
  endfunction

  function automatic alloc_req_t random_word();
    alloc_req_t it;
    int unsigned r, k;
    it.kind = KIND_ALLOC;
    it.req_bytes = BYTES_W'($urandom_range(0, 1048576));
    it.payload_addr = ADDR_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 38 && granted_q.size() > 0) begin
      // free a granted block; keep it listed now and then for a double free
      it.kind = KIND_FREE;
      k = $urandom_range(0, granted_q.size() - 1);
      it.payload_addr = granted_q[k];
      if ($urandom_range(0, 9) != 0) granted_q.delete(k);
    end else if (r < 44) begin
      // bad free: misaligned, below the header, or past the break
      it.kind = KIND_FREE;
      case ($urandom_range(0, 2))
        0: it.payload_addr = ADDR_W'($urandom_range(0, 15));
        1: it.payload_addr = ADDR_W'(($urandom & 20'hFFFE0) | $urandom_range(17, 47) % 32)
                             | 20'h1;
        default: it.payload_addr = ADDR_W'($urandom_range(brk_q, 1048575) & ~32'h1F) | 20'h10;
      endcase
      if (it.payload_addr >= 16 && (it.payload_addr - 16) % 32 == 0 &&
          BYTES_W'(it.payload_addr - 16) < brk_q)
        it.payload_addr = 20'd0;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 60) it.req_bytes = BYTES_W'($urandom_range(1, 100));
      else if (k < 85) it.req_bytes = BYTES_W'($urandom_range(101, 4000));
      else if (k < 97) it.req_bytes = BYTES_W'($urandom_range(4001, 100000));
      else if (k < 99) it.req_bytes = BYTES_W'($urandom_range(100001, 1048576));
      else it.req_bytes = '0;
    end
    return it;
  endfunction

  // Driver: present pending words with random gaps, predict on acceptance.
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    alloc_req_t it;
    logic       nxt_valid;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        it.kind = kind_i;
        it.req_bytes = req_bytes_i;
        it.payload_addr = payload_addr_i;
        expected_q.push_back(predict_alloc(it));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          kind_i <= it.kind;
          req_bytes_i <= it.req_bytes;
          payload_addr_i <= it.payload_addr;
          nxt_valid = 1'b1;
          in_gap = gap_len();
        end
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Monitor: random stalls, compare each accepted word with the oldest prediction.
  int unsigned out_gap = 0;
  always @(posedge clk_i) begin
    alloc_rsp_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result ok=%0b addr=%h", $realtime, ok_o, block_addr_o);
        errors++;
      end else begin
        exp_w = expected_q.pop_front();
        if (ok_o !== exp_w.ok) begin
          $display("%0t: ok expected %0b actual %0b", $realtime, exp_w.ok, ok_o);
          errors++;
        end
        if (block_addr_o !== exp_w.block_addr) begin
          $display("%0t: block_addr expected %h actual %h", $realtime,
                   exp_w.block_addr, block_addr_o);
          errors++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_gap = gap_len();
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sample at the falling edge, once the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [BYTES_W-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    limit_q = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_word(logic kind, int unsigned req, int unsigned addr);
    alloc_req_t it;
    it.kind = kind;
    it.req_bytes = BYTES_W'(req);
    it.payload_addr = ADDR_W'(addr);
    pending_q.push_back(it);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) begin
      while (pending_q.size() > 0) @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) calm = !calm;
      pending_q.push_back(random_word());
    end
  endtask

  initial begin
    foreach (head_q[i]) head_q[i] = '0;
    foreach (link_mem[i]) link_mem[i] = '0;
    foreach (lvl_mem[i]) lvl_mem[i] = '0;
    brk_q = BYTES_W'(1 << CHUNK_LOG2);
    limit_q = BYTES_W'(1048576);
    push_free(START_LVL, '0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    add_word(KIND_ALLOC, 0, 20'hFFFFF);
    add_word(KIND_ALLOC, 1, 0);
    add_word(KIND_ALLOC, 16, 0);
    add_word(KIND_ALLOC, 17, 0);
    add_word(KIND_ALLOC, 1048576, 0);
    add_word(KIND_ALLOC, 1048575, 0);
    add_word(KIND_ALLOC, 1048560, 0);
    add_word(KIND_ALLOC, 262128, 0);
    add_word(KIND_ALLOC, 524272, 0);
    add_word(KIND_FREE, 1048576, 0);
    add_word(KIND_FREE, 0, 15);
    add_word(KIND_FREE, 0, 17);
    add_word(KIND_FREE, 0, 20'hFFFFF);
    add_word(KIND_FREE, 0, 20'hFFFF0);
    add_word(KIND_FREE, 0, 16);
    add_word(KIND_FREE, 0, 16);
    add_word(KIND_ALLOC, 10, 0);
    add_word(KIND_ALLOC, 10, 0);
    add_word(KIND_ALLOC, 10, 0);
    add_word(KIND_FREE, 0, 48);
    wait_idle();

    write_limit(BYTES_W'(262144));
    add_word(KIND_ALLOC, 262128, 0);
    add_word(KIND_ALLOC, 100, 0);
    run_random(300);
    write_limit(BYTES_W'(1048576));
    run_random(350);
    write_limit(BYTES_W'($urandom_range(262144, 1048576)));
    run_random(300);
    write_limit(BYTES_W'(1048576));
    run_random(300);

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
